// File: design/pfq_pkg.sv
// Shared types, codes and default sizes of the priority frame queue.
// No dependencies; pfq_cell, priority_frame_queue and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package pfq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 64;
  localparam int DEF_FRAME_BITS    = 8;
  localparam int DEF_PRIORITY_BITS = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  // Slot update broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    logic eval;  // register compare flags this cycle
    op_t  op;    // slot update this cycle
  } ctrl_t;

endpackage

// File: design/pfq_req_if.sv
// Command channel of the priority frame queue: valid/ready plus command payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfq_req_if #(
  parameter int FRAME_BITS    = 8,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [FRAME_BITS-1:0]    frame_number;
  logic [PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, command, frame_number, priority_req, input ready);
  modport sink   (input valid, command, frame_number, priority_req, output ready);
endinterface

// File: design/pfq_rsp_if.sv
// Result channel of the priority frame queue: valid/ready plus result payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface pfq_rsp_if #(
  parameter int FRAME_BITS = 8,
  parameter int OCC_BITS   = 7
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] frame_out;
  logic [1:0]            status;
  logic [OCC_BITS-1:0]   occupancy;

  modport source (output valid, frame_out, status, occupancy, input ready);
  modport sink   (input valid, frame_out, status, occupancy, output ready);
endinterface

// File: design/pfq_cell.sv
// One sorted slot of the queue: holds a frame, its priority and a valid bit,
// registers its compare flags and shifts with its neighbors. Uses pfq_pkg.
`timescale 1ns / 1ps

module pfq_cell #(
  parameter int FRAME_BITS    = pfq_pkg::DEF_FRAME_BITS,
  parameter int PRIORITY_BITS = pfq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pfq_pkg::ctrl_t           ctrl,
  input  logic [FRAME_BITS-1:0]    key_frame,
  input  logic [PRIORITY_BITS-1:0] key_prio,
  input  logic                     ge_left,    // left slot stays ahead of a new entry
  input  logic                     seen,       // removal hit at this slot or nearer head
  input  logic [FRAME_BITS-1:0]    left_frame,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic                     left_valid,
  input  logic [FRAME_BITS-1:0]    right_frame,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic                     right_valid,
  output logic [FRAME_BITS-1:0]    frame,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     valid,
  output logic                     ge,
  output logic                     match
);

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      ge    <= valid && (prio >= key_prio);
      match <= valid && (frame == key_frame);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        pfq_pkg::OP_INSERT: begin
          if (!ge) begin
            if (ge_left) begin
              frame <= key_frame;
              prio  <= key_prio;
              valid <= 1'b1;
            end else begin
              frame <= left_frame;
              prio  <= left_prio;
              valid <= left_valid;
            end
          end
        end
        pfq_pkg::OP_POP: begin
          frame <= right_frame;
          prio  <= right_prio;
          valid <= right_valid;
        end
        pfq_pkg::OP_REMOVE: begin
          if (seen) begin
            frame <= right_frame;
            prio  <= right_prio;
            valid <= right_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/pfq_prefix_or.sv
// Inclusive prefix OR over the per-slot match flags, log-depth.
// Depends on nothing.
`timescale 1ns / 1ps

module pfq_prefix_or #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] hits,
  output logic [WIDTH-1:0] seen
);

  localparam int STEPS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  always_comb begin
    logic [WIDTH-1:0] p;
    p = hits;
    for (int d = 0; d < STEPS; d++) begin
      p = p | (p << (1 << d));
    end
    seen = p;
  end

endmodule

// File: design/priority_frame_queue.sv
// Top level of the priority frame queue: slot row, match prefix, control, result.
// Depends on pfq_pkg, pfq_req_if, pfq_rsp_if, pfq_cell and pfq_prefix_or.
`timescale 1ns / 1ps

// Bounded priority queue of frame numbers held in a row of QUEUE_DEPTH
// slots, slot 0 being the head, sorted by descending priority with equal
// priorities in arrival order. Commands: insert (0), pop head (1), remove
// first slot holding a given frame (2); code 3 does nothing. Every command
// transaction yields one result transaction with the frame popped or
// removed (zero otherwise), a status (ok, not found, empty, full) and the
// occupancy after the command. Each command passes through a compare
// cycle in which every slot registers whether its priority is at least the
// new one and whether its frame matches, then an update cycle in which the
// affected slots shift toward head or tail at once. A new command is taken
// while idle or in the update cycle, so back-to-back commands skip the idle
// state as long as results are drained; while an unread result sits in the
// output register the update cycle waits. No clearing pass is needed after
// reset: slot valid bits are cleared directly.
module priority_frame_queue #(
  parameter int QUEUE_DEPTH   = pfq_pkg::DEF_QUEUE_DEPTH,
  parameter int FRAME_BITS    = pfq_pkg::DEF_FRAME_BITS,
  parameter int PRIORITY_BITS = pfq_pkg::DEF_PRIORITY_BITS,
  parameter int OCC_BITS      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic      clk,
  input  logic      rst,
  pfq_req_if.sink   req,
  pfq_rsp_if.source rsp
);

  pfq_pkg::state_t state, state_next;
  pfq_pkg::ctrl_t  ctrl;

  // Command latched at acceptance; frame and priority are broadcast to the slot row.
  pfq_pkg::cmd_t            key_cmd;
  logic [FRAME_BITS-1:0]    key_frame;
  logic [PRIORITY_BITS-1:0] key_prio;

  logic [OCC_BITS-1:0] count, count_next;

  // Output register.
  logic                  out_valid;
  logic [FRAME_BITS-1:0] out_frame, out_frame_next;
  pfq_pkg::status_t      out_status, out_status_next;
  logic                  out_load;

  logic out_can;
  logic in_fire;
  logic ready;

  // Slot row.
  logic [FRAME_BITS-1:0]    slot_frame [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] slot_prio  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   slot_valid;
  logic [QUEUE_DEPTH-1:0]   slot_ge;
  logic [QUEUE_DEPTH-1:0]   slot_match;
  logic [QUEUE_DEPTH-1:0]   slot_seen;

  logic is_full;
  logic is_empty;
  logic found;

  assign is_full  = (count == OCC_BITS'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign found    = slot_seen[QUEUE_DEPTH-1];

  assign out_can = !out_valid || rsp.ready;
  assign ready   = (state == pfq_pkg::S_IDLE) || ((state == pfq_pkg::S_APPLY) && out_can);
  assign in_fire = req.valid && ready;
  assign req.ready = ready;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      logic                     ge_l;
      logic [FRAME_BITS-1:0]    frame_l, frame_r;
      logic [PRIORITY_BITS-1:0] prio_l, prio_r;
      logic                     valid_l, valid_r;

      if (i == 0) begin : g_head
        assign ge_l    = 1'b1;   // head: new entry goes here unless head stays ahead
        assign frame_l = key_frame;
        assign prio_l  = key_prio;
        assign valid_l = 1'b0;
      end else begin : g_body
        assign ge_l    = slot_ge[i-1];
        assign frame_l = slot_frame[i-1];
        assign prio_l  = slot_prio[i-1];
        assign valid_l = slot_valid[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign frame_r = '0;
        assign prio_r  = '0;
        assign valid_r = 1'b0;
      end else begin : g_inner
        assign frame_r = slot_frame[i+1];
        assign prio_r  = slot_prio[i+1];
        assign valid_r = slot_valid[i+1];
      end

      pfq_cell #(
        .FRAME_BITS    (FRAME_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .key_frame   (key_frame),
        .key_prio    (key_prio),
        .ge_left     (ge_l),
        .seen        (slot_seen[i]),
        .left_frame  (frame_l),
        .left_prio   (prio_l),
        .left_valid  (valid_l),
        .right_frame (frame_r),
        .right_prio  (prio_r),
        .right_valid (valid_r),
        .frame       (slot_frame[i]),
        .prio        (slot_prio[i]),
        .valid       (slot_valid[i]),
        .ge          (slot_ge[i]),
        .match       (slot_match[i])
      );
    end
  endgenerate

  // First matching slot and everything behind it shift toward head on remove.
  pfq_prefix_or #(
    .WIDTH (QUEUE_DEPTH)
  ) u_prefix (
    .hits (slot_match),
    .seen (slot_seen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ctrl.eval       = 1'b0;
    ctrl.op         = pfq_pkg::OP_HOLD;
    count_next      = count;
    out_load        = 1'b0;
    out_frame_next  = '0;
    out_status_next = pfq_pkg::ST_OK;
    case (state)
      pfq_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = pfq_pkg::S_EVAL;
        end
      end
      pfq_pkg::S_EVAL: begin
        ctrl.eval  = 1'b1;
        state_next = pfq_pkg::S_APPLY;
      end
      pfq_pkg::S_APPLY: begin
        if (out_can) begin
          out_load   = 1'b1;
          state_next = in_fire ? pfq_pkg::S_EVAL : pfq_pkg::S_IDLE;
          case (key_cmd)
            pfq_pkg::CMD_INSERT: begin
              if (is_full) begin
                out_status_next = pfq_pkg::ST_FULL;
              end else begin
                ctrl.op    = pfq_pkg::OP_INSERT;
                count_next = count + OCC_BITS'(1);
              end
            end
            pfq_pkg::CMD_POP: begin
              if (is_empty) begin
                out_status_next = pfq_pkg::ST_EMPTY;
              end else begin
                ctrl.op        = pfq_pkg::OP_POP;
                count_next     = count - OCC_BITS'(1);
                out_frame_next = slot_frame[0];
              end
            end
            pfq_pkg::CMD_REMOVE: begin
              if (found) begin
                ctrl.op        = pfq_pkg::OP_REMOVE;
                count_next     = count - OCC_BITS'(1);
                out_frame_next = key_frame;
              end else begin
                out_status_next = pfq_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = pfq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_cmd   <= pfq_pkg::cmd_t'(req.command);
      key_frame <= req.frame_number;
      key_prio  <= req.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame  <= out_frame_next;
      out_status <= out_status_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.frame_out = out_frame;
  assign rsp.status    = out_status;
  assign rsp.occupancy = count;

  // Occupied slots always equal the entry count.
  a_count_matches_slots: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == 32'(count))
    else $error("slot valid bits disagree with entry count");

  // Count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OCC_BITS'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // An accepted transaction is always followed by its compare cycle.
  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == pfq_pkg::S_EVAL)
    else $error("accepted transaction not evaluated");

  // A full queue rejects inserts without touching the slots.
  a_full_no_insert: assert property (@(posedge clk) disable iff (rst)
    (state == pfq_pkg::S_APPLY && key_cmd == pfq_pkg::CMD_INSERT && is_full)
      |-> ctrl.op == pfq_pkg::OP_HOLD)
    else $error("insert applied to full queue");

endmodule

// File: tb/sv/tb_priority_frame_queue.sv
// Self-checking testbench for priority_frame_queue: directed and random command streams.
// Depends on pfq_pkg, pfq_req_if, pfq_rsp_if and the priority_frame_queue RTL.
`timescale 1ns / 1ps

module tb_priority_frame_queue;

  localparam int DEPTH      = 64;
  localparam int FBITS      = 8;
  localparam int PBITS      = 8;
  localparam int OBITS      = 7;
  localparam int N_DIRECTED = 19;
  localparam int N_RANDOM   = 950;
  localparam int N_CALM     = 80;     // tail of the run with no idling anywhere
  localparam int HOLD_AT    = 300;    // random transaction that triggers the long stall
  localparam int HOLD_LEN   = 300;    // cycles the result side stays blocked
  localparam int DRAIN_WAIT = 10;
  localparam int MAX_CYCLES = 400000;

  // One occupied slot of the queue.
  typedef struct {
    logic [FBITS-1:0] frame;
    logic [PBITS-1:0] prio;
  } slot_t;

  // What the block must answer for one command.
  typedef struct {
    logic [FBITS-1:0] frame;
    pfq_pkg::status_t status;
    logic [OBITS-1:0] occ;
  } outcome_t;

  // Shadow copy of the sorted slot row plus the results still owed by the block.
  class pfq_shadow;
    slot_t    slots[$];
    outcome_t owed_results[$];
    int       errors;
    int       n_cmd[4];
    int       n_status[4];
    int       max_occ;

    function int slot_of(logic [FBITS-1:0] frame);
      foreach (slots[i])
        if (slots[i].frame == frame) return i;
      return -1;
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_command(pfq_pkg::cmd_t cmd, logic [FBITS-1:0] frame,
                               logic [PBITS-1:0] prio);
      outcome_t o;
      slot_t    s;
      int       pos;
      o.frame  = '0;
      o.status = pfq_pkg::ST_OK;
      case (cmd)
        pfq_pkg::CMD_INSERT: begin
          if (slots.size() >= DEPTH) begin
            o.status = pfq_pkg::ST_FULL;
          end else begin
            // new entry goes behind every slot of equal or higher priority
            pos = 0;
            while (pos < slots.size() && slots[pos].prio >= prio) pos++;
            s.frame = frame;
            s.prio  = prio;
            slots.insert(pos, s);
          end
        end
        pfq_pkg::CMD_POP: begin
          if (slots.size() == 0) begin
            o.status = pfq_pkg::ST_EMPTY;
          end else begin
            o.frame = slots[0].frame;
            slots.delete(0);
          end
        end
        pfq_pkg::CMD_REMOVE: begin
          pos = slot_of(frame);
          if (pos < 0) begin
            o.status = pfq_pkg::ST_NOT_FOUND;
          end else begin
            o.frame = frame;
            slots.delete(pos);
          end
        end
        default: ;
      endcase
      o.occ = OBITS'(slots.size());
      if (slots.size() > max_occ) max_occ = slots.size();
      n_cmd[cmd]++;
      n_status[o.status]++;
      owed_results.push_back(o);
    endfunction

    function void check_result(logic [FBITS-1:0] frame, logic [1:0] status,
                               logic [OBITS-1:0] occ);
      outcome_t o;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: frame %0d status %0d occupancy %0d",
                 $time, frame, status, occ);
        return;
      end
      o = owed_results.pop_front();
      if (frame !== o.frame) begin
        errors++;
        $display("%0t: frame_out expected %0d actual %0d", $time, o.frame, frame);
      end
      if (status !== o.status) begin
        errors++;
        $display("%0t: status expected %s actual %0d", $time, o.status.name(), status);
      end
      if (occ !== o.occ) begin
        errors++;
        $display("%0t: occupancy expected %0d actual %0d", $time, o.occ, occ);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  pfq_req_if #(.FRAME_BITS(FBITS), .PRIORITY_BITS(PBITS)) req_if ();
  pfq_rsp_if #(.FRAME_BITS(FBITS), .OCC_BITS(OBITS))      rsp_if ();

  priority_frame_queue #(
    .QUEUE_DEPTH  (DEPTH),
    .FRAME_BITS   (FBITS),
    .PRIORITY_BITS(PBITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  pfq_shadow shadow = new();

  int  cycles;
  int  items_sent;
  bit  calm;           // no idling on either side once set
  bit  sender_idles;   // per-episode switch for gaps on the command side
  bit  hold_request;   // asks the result side for one long stall
  int  long_holds;
  int  prio_mode;

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: covers a hung handshake and results that never show up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("%0t: timeout, %0d results still owed", $time, shadow.owed_results.size());
      $display("[priority_frame_queue] ERROR");
      $finish;
    end
  end

  // Result monitor: a transaction completes when valid and ready meet at an edge.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      shadow.check_result(rsp_if.frame_out, rsp_if.status, rsp_if.occupancy);
  end

  // Result side back-pressure: random stall bursts, free-running stretches,
  // and one long block on request so the command side backs up behind it.
  initial begin
    rsp_if.ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        long_holds++;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Drop valid for a burst of cycles; payload is scrambled meanwhile.
  task automatic pause_sender(int n);
    req_if.valid        <= 1'b0;
    req_if.command      <= 2'($urandom_range(0, 3));
    req_if.frame_number <= FBITS'($urandom);
    req_if.priority_req <= PBITS'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Offer one command (after an optional gap) and wait for it to be taken.
  // valid stays high on return so back-to-back commands need no re-raise.
  task automatic send_command(pfq_pkg::cmd_t cmd, logic [FBITS-1:0] frame,
                              logic [PBITS-1:0] prio);
    if (!calm && sender_idles && $urandom_range(0, 3) == 0)
      pause_sender($urandom_range(1, 13));
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.frame_number <= frame;
    req_if.priority_req <= prio;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    shadow.note_command(cmd, frame, prio);
    items_sent++;
    if (items_sent == N_DIRECTED + HOLD_AT) hold_request = 1'b1;
    if (items_sent >= N_DIRECTED + N_RANDOM - N_CALM) calm = 1'b1;
  endtask

  // Priority spread for the current episode: narrow bands force many ties
  // so the FIFO order among equals gets exercised.
  function automatic logic [PBITS-1:0] pick_priority();
    case (prio_mode)
      0:       return PBITS'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return PBITS'($urandom_range(126, 129));
      default: return PBITS'($urandom);
    endcase
  endfunction

  task automatic send_remove_present();
    int idx;
    idx = $urandom_range(0, shadow.slots.size() - 1);
    send_command(pfq_pkg::CMD_REMOVE, shadow.slots[idx].frame, PBITS'($urandom));
  endtask

  task automatic send_remove_absent();
    logic [FBITS-1:0] f;
    do f = FBITS'($urandom); while (shadow.slot_of(f) >= 0);
    send_command(pfq_pkg::CMD_REMOVE, f, PBITS'($urandom));
  endtask

  // General traffic, weighted toward inserts so the queue keeps some depth.
  task automatic mixed_episode(int len);
    int r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        send_command(pfq_pkg::CMD_INSERT, FBITS'($urandom), pick_priority());
      else if (r < 70)
        send_command(pfq_pkg::CMD_POP, FBITS'($urandom), PBITS'($urandom));
      else if (r < 87 && shadow.slots.size() > 0)
        send_remove_present();
      else if (r < 96)
        send_remove_absent();
      else
        send_command(pfq_pkg::CMD_NOP, FBITS'($urandom), PBITS'($urandom));
    end
  endtask

  initial begin
    int ep;
    int extra;

    cycles       = 0;
    items_sent   = 0;
    calm         = 1'b0;
    sender_idles = 1'b1;
    hold_request = 1'b0;
    long_holds   = 0;
    prio_mode    = 3;

    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.command      <= pfq_pkg::CMD_NOP;
    req_if.frame_number <= '0;
    req_if.priority_req <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-queue corners, ties, extremes, duplicate frames, unused code.
    sender_idles = 1'b0;
    send_command(pfq_pkg::CMD_POP,    8'h00, 8'h00);   // pop on empty
    send_command(pfq_pkg::CMD_REMOVE, 8'h00, 8'hFF);   // remove on empty
    send_command(pfq_pkg::CMD_NOP,    8'hFF, 8'hFF);
    send_command(pfq_pkg::CMD_INSERT, 8'hA5, 8'h80);
    send_command(pfq_pkg::CMD_INSERT, 8'h5A, 8'h80);   // tie: lands behind A5
    send_command(pfq_pkg::CMD_INSERT, 8'hFF, 8'hFF);   // new head
    send_command(pfq_pkg::CMD_INSERT, 8'h00, 8'h00);   // new tail
    send_command(pfq_pkg::CMD_INSERT, 8'h5A, 8'h01);   // same frame again, lower priority
    send_command(pfq_pkg::CMD_INSERT, 8'h33, 8'h80);   // third of the tie group
    send_command(pfq_pkg::CMD_NOP,    8'h12, 8'h34);   // occupancy must be unchanged
    send_command(pfq_pkg::CMD_REMOVE, 8'h5A, 8'h00);   // only the copy nearest the head goes
    send_command(pfq_pkg::CMD_REMOVE, 8'h77, 8'h00);   // absent frame
    send_command(pfq_pkg::CMD_REMOVE, 8'h00, 8'h00);   // tail removal
    send_command(pfq_pkg::CMD_POP,    8'h00, 8'h00);
    sender_idles = 1'b1;
    send_command(pfq_pkg::CMD_POP,    8'hFF, 8'hFF);
    send_command(pfq_pkg::CMD_POP,    8'h00, 8'h00);
    send_command(pfq_pkg::CMD_POP,    8'h00, 8'h00);   // last entry
    send_command(pfq_pkg::CMD_POP,    8'h00, 8'h00);   // empty again
    send_command(pfq_pkg::CMD_REMOVE, 8'hFF, 8'h00);

    // Random episodes: fill to full, mix starting at full depth, drain past empty, mix.
    ep = 0;
    while (items_sent < N_DIRECTED + N_RANDOM) begin
      prio_mode    = $urandom_range(0, 4);
      sender_idles = $urandom_range(0, 2) != 0;
      case (ep % 4)
        0: begin
          extra = $urandom_range(1, 4);     // inserts against a full queue
          while (shadow.slots.size() < DEPTH)
            send_command(pfq_pkg::CMD_INSERT, FBITS'($urandom), pick_priority());
          repeat (extra)
            send_command(pfq_pkg::CMD_INSERT, FBITS'($urandom), pick_priority());
        end
        2: begin
          extra = $urandom_range(1, 3);     // pops against an empty queue
          while (shadow.slots.size() > 0)
            send_command(pfq_pkg::CMD_POP, FBITS'($urandom), PBITS'($urandom));
          repeat (extra)
            send_command(pfq_pkg::CMD_POP, FBITS'($urandom), PBITS'($urandom));
        end
        default: mixed_episode($urandom_range(20, 60));
      endcase
      ep++;
    end

    // Let the block finish: every owed result must arrive, then a short tail.
    pause_sender(1);
    while (shadow.owed_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d commands (insert %0d, pop %0d, remove %0d, unused %0d), peak depth %0d,",
             items_sent, shadow.n_cmd[pfq_pkg::CMD_INSERT], shadow.n_cmd[pfq_pkg::CMD_POP],
             shadow.n_cmd[pfq_pkg::CMD_REMOVE], shadow.n_cmd[pfq_pkg::CMD_NOP],
             shadow.max_occ);
    $display("full %0d, empty %0d, not-found %0d, long result stalls %0d, %0d mismatches.",
             shadow.n_status[pfq_pkg::ST_FULL], shadow.n_status[pfq_pkg::ST_EMPTY],
             shadow.n_status[pfq_pkg::ST_NOT_FOUND], long_holds, shadow.errors);
    if (shadow.errors == 0 && shadow.owed_results.size() == 0) begin
      $display("[priority_frame_queue] OK");
    end else begin
      $display("[priority_frame_queue] ERROR");
    end
    $finish;
  end

endmodule
